### rtl/core/icdg_pkg.sv
// ----------------------------------------------------------------------------
// Central difference image gradient: shared definitions
// Field widths, register indexes, item kinds and reset values used by the
// gradient core and its port checker.
// ----------------------------------------------------------------------------
package icdg_pkg;

  localparam int unsigned GradW       = 18;
  localparam int unsigned RowW        = 12;
  localparam int unsigned ColW        = 12;
  localparam int unsigned RowCntW     = 13;
  localparam int unsigned SampleInW   = 16;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned HeightLimit = 4096;

  localparam logic [CfgDataW-1:0] WidthReset  = 13'd640;
  localparam logic [CfgDataW-1:0] HeightReset = 13'd480;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_e;

endpackage

### rtl/core/image_central_difference_gradient_top.sv
// ----------------------------------------------------------------------------
// Central difference image gradient
// Raster-order pixel stream in, horizontal and vertical half-unit gradients
// out, using two line memories for the previous and the current row.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall_o is low. A result goes
// through the p1 stage and then the output register. The result for
// a pixel of row r comes out when the pixel of the same column in row r + 1
// arrives, so the first row gives no results; after the last row the host
// sends one flush item per column to drain it, and the flush of the last
// column carries frame_last. Each line memory is read at one address and
// written at one address per cycle, and the neighbouring samples a result
// needs are kept in a short chain of registers fed by a read one column ahead.
module image_central_difference_gradient_top #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [icdg_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [icdg_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [icdg_pkg::SampleInW-1:0]       sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [icdg_pkg::GradW-1:0]    grad_x_half_o,
  output logic signed [icdg_pkg::GradW-1:0]    grad_y_half_o,
  output logic [icdg_pkg::RowW-1:0]            pixel_row_o,
  output logic [icdg_pkg::ColW-1:0]            pixel_col_o,
  output logic                                 frame_last_o
);
  import icdg_pkg::*;

  localparam int unsigned AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned DiffW = SAMPLE_BITS + 2;

  typedef struct packed {
    logic [AddrW-1:0] col;
    logic [RowW-1:0]  row;
    logic             first_col;
    logic             last_col;
    logic             flush;
    logic             row_one;
  } p1_ctrl_t;

  logic [CfgDataW-1:0]    width_q, height_q;
  logic [AddrW-1:0]       col_q, col_d;
  logic [RowCntW-1:0]     row_q, row_d, row_inc;
  logic                   drain_q, drain_d;
  logic [31:0]            w_eff, h_eff;
  logic [AddrW-1:0]       w_last, c, c_inc, rd_addr;
  logic                   last_col, first_col, ignore, row0;
  logic                   in_acc, step, p1_adv, newer_we, older_we;

  logic [SAMPLE_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] older_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] nw_rd_q, ol_rd_q, nw_cur_q, nw_prev_q, s_in;

  logic                   p1_valid_q;
  p1_ctrl_t               p1_ctrl_q;
  logic [SAMPLE_BITS-1:0] p1_sample_q;

  logic [SAMPLE_BITS-1:0] gx_a, gx_b, gy_a, gy_b;
  logic signed [DiffW-1:0] gx_diff, gy_diff, gx_val, gy_val;
  logic                   gx_dbl, gy_dbl;

  logic                   out_valid_q;
  logic signed [GradW-1:0] gx_q, gy_q;
  logic [RowW-1:0]        out_row_q;
  logic [ColW-1:0]        out_col_q;
  logic                   out_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = 32'(width_q);
    if (w_eff < 32'd2) w_eff = 32'd2;
    if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    h_eff = 32'(height_q);
    if (h_eff < 32'd2) h_eff = 32'd2;
    if (h_eff > 32'(HeightLimit)) h_eff = 32'(HeightLimit);
  end

  assign w_last    = AddrW'(w_eff - 32'd1);
  assign c         = (32'(col_q) >= w_eff) ? w_last : col_q;
  assign c_inc     = c + AddrW'(1);
  assign last_col  = (c == w_last);
  assign first_col = (c == '0);
  assign rd_addr   = last_col ? '0 : c_inc;
  assign row_inc   = row_q + RowCntW'(1);
  assign ignore    = !drain_q && (kind_i == KIND_FLUSH);
  assign row0      = !drain_q && (row_q == '0);
  assign s_in      = SAMPLE_BITS'(sample_i);

  assign p1_adv     = p1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = p1_valid_q && !p1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign step       = in_acc && !ignore;
  assign newer_we   = step && !drain_q;
  assign older_we   = step && !row0;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (step) begin
      if (row0) begin
        if (last_col) begin
          col_d = '0;
          row_d = RowCntW'(1);
        end else begin
          col_d = c_inc;
        end
      end else if (!last_col) begin
        col_d = c_inc;
      end else if (drain_q) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = 1'b0;
      end else begin
        col_d = '0;
        row_d = row_inc;
        if (32'(row_inc) >= h_eff) drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  // The newer row is read one column ahead; the write of the older row takes
  // the value read for this column by the previous transfer.
  always_ff @(posedge clk_i) begin
    if (step) begin
      nw_rd_q <= newer_mem[rd_addr];
      if (newer_we) newer_mem[c] <= s_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ol_rd_q <= older_mem[c];
      if (older_we) older_mem[c] <= nw_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      nw_cur_q  <= nw_rd_q;
      nw_prev_q <= nw_cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (step && !row0) begin
      p1_valid_q <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && !row0) begin
      p1_ctrl_q.col       <= c;
      p1_ctrl_q.row       <= RowW'(row_q - RowCntW'(1));
      p1_ctrl_q.first_col <= first_col;
      p1_ctrl_q.last_col  <= last_col;
      p1_ctrl_q.flush     <= drain_q;
      p1_ctrl_q.row_one   <= (row_q == RowCntW'(1));
      p1_sample_q         <= s_in;
    end
  end

  always_comb begin
    gx_dbl = 1'b0;
    gx_a   = nw_rd_q;
    gx_b   = nw_prev_q;
    if (p1_ctrl_q.first_col) begin
      gx_dbl = 1'b1;
      gx_b   = nw_cur_q;
    end else if (p1_ctrl_q.last_col) begin
      gx_dbl = 1'b1;
      gx_a   = nw_cur_q;
    end

    gy_dbl = 1'b0;
    gy_a   = p1_sample_q;
    gy_b   = ol_rd_q;
    if (p1_ctrl_q.flush) begin
      gy_dbl = 1'b1;
      gy_a   = nw_cur_q;
    end else if (p1_ctrl_q.row_one) begin
      gy_dbl = 1'b1;
      gy_b   = nw_cur_q;
    end

    gx_diff = $signed({2'b00, gx_a}) - $signed({2'b00, gx_b});
    gy_diff = $signed({2'b00, gy_a}) - $signed({2'b00, gy_b});
    gx_val  = gx_dbl ? (gx_diff <<< 1) : gx_diff;
    gy_val  = gy_dbl ? (gy_diff <<< 1) : gy_diff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      gx_q       <= GradW'(gx_val);
      gy_q       <= GradW'(gy_val);
      out_row_q  <= p1_ctrl_q.row;
      out_col_q  <= ColW'(p1_ctrl_q.col);
      out_last_q <= p1_ctrl_q.flush && p1_ctrl_q.last_col;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign grad_x_half_o = gx_q;
  assign grad_y_half_o = gy_q;
  assign pixel_row_o   = out_row_q;
  assign pixel_col_o   = out_col_q;
  assign frame_last_o  = out_last_q;

endmodule

### rtl/core/icdg_checker.sv
// ----------------------------------------------------------------------------
// Central difference image gradient: port checker
// Watches the ports of the gradient core and flags results that break the
// output transfer rules or the border arithmetic.
// ----------------------------------------------------------------------------
module icdg_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_valid_i,
  input logic                                 cfg_ready_o,
  input logic [icdg_pkg::CfgIdxW-1:0]         cfg_index_i,
  input logic [icdg_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 kind_i,
  input logic [icdg_pkg::SampleInW-1:0]       sample_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [icdg_pkg::GradW-1:0]    grad_x_half_o,
  input logic signed [icdg_pkg::GradW-1:0]    grad_y_half_o,
  input logic [icdg_pkg::RowW-1:0]            pixel_row_o,
  input logic [icdg_pkg::ColW-1:0]            pixel_col_o,
  input logic                                 frame_last_o
);
  import icdg_pkg::*;

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(grad_x_half_o)
      && $stable(grad_y_half_o) && $stable(pixel_row_o) && $stable(pixel_col_o)
      && $stable(frame_last_o))
    else $error("stalled result changed");

  // The first column uses a doubled one-sided difference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pixel_col_o == '0) |-> (grad_x_half_o[0] == 1'b0))
    else $error("odd horizontal gradient in the first column");

  // The first row uses a doubled one-sided difference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pixel_row_o == '0) |-> (grad_y_half_o[0] == 1'b0))
    else $error("odd vertical gradient in the first row");

  // The final pixel of an image never lies in its first row or column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> (pixel_row_o != '0) && (pixel_col_o != '0))
    else $error("frame end marked on a first row or column");

endmodule

bind image_central_difference_gradient_top icdg_checker u_icdg_checker (.*);

### bench/image_central_difference_gradient_top_tb.sv
// ----------------------------------------------------------------------------
// Central difference image gradient: self-checking testbench
// Streams raster-order frames and flush items into the gradient block and
// checks every result against a behavioural predictor kept alongside. A
// directed part covers edge values, register clamping, reset values, a
// register change mid-frame and a long output hold-off. A random part follows,
// with random stalls on both sides and a pause until all results have arrived.
// ----------------------------------------------------------------------------
module image_central_difference_gradient_top_tb;
  import icdg_pkg::*;

  localparam int unsigned MaxWidth      = 4096;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned RandomItems   = 900;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned TimeoutCycles = 1_500_000;
  localparam int unsigned MaxPrinted    = 40;

  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  typedef struct packed {
    logic [GradW-1:0] grad_x;
    logic [GradW-1:0] grad_y;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             last;
  } gradient_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  kind_i;
  logic [SampleInW-1:0]  sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [GradW-1:0] grad_x_half_o;
  logic signed [GradW-1:0] grad_y_half_o;
  logic [RowW-1:0]       pixel_row_o;
  logic [ColW-1:0]       pixel_col_o;
  logic                  frame_last_o;

  // Predictor state: line stores, position in the frame and register copies.
  logic [SampleInW-1:0] prev_line [MaxWidth];
  logic [SampleInW-1:0] curr_line [MaxWidth];
  int unsigned          col_pos;
  logic [RowCntW-1:0]   row_pos;
  logic                 in_drain;
  logic [CfgDataW-1:0]  cfg_width;
  logic [CfgDataW-1:0]  cfg_height;

  gradient_t   expected_grads [$];
  int unsigned items_accepted;
  int unsigned items_ignored;
  int unsigned frames_done;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned hold_cycles_left;
  logic        gaps_on;
  logic        stalls_on;

  image_central_difference_gradient_top #(
    .MAX_WIDTH  (MaxWidth),
    .SAMPLE_BITS(SampleInW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .grad_x_half_o(grad_x_half_o),
    .grad_y_half_o(grad_y_half_o),
    .pixel_row_o  (pixel_row_o),
    .pixel_col_o  (pixel_col_o),
    .frame_last_o (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("timeout with %0d results outstanding", expected_grads.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic void predict_gradient(input item_kind_e kind,
                                           input logic [SampleInW-1:0] value);
    int unsigned        w;
    int unsigned        h;
    int unsigned        c;
    longint             gx;
    longint             gy;
    logic               flush;
    logic               last_col;
    logic [RowCntW-1:0] out_row;
    gradient_t          res;
    w = (cfg_width < 2) ? 2 : ((cfg_width > MaxWidth) ? MaxWidth : cfg_width);
    h = (cfg_height < 2) ? 2 : ((cfg_height > HeightLimit) ? HeightLimit : cfg_height);
    flush = in_drain;
    if (!in_drain && kind == KIND_FLUSH) begin
      items_ignored++;
      return;
    end
    if (col_pos >= w) col_pos = w - 1;
    c = col_pos;
    last_col = (c == w - 1);
    if (!flush && row_pos == 0) begin
      curr_line[c] = value;
      if (last_col) begin
        col_pos = 0;
        row_pos = 1;
      end else begin
        col_pos = c + 1;
      end
      return;
    end
    if (c == 0) gx = 2 * (longint'(curr_line[1]) - longint'(curr_line[0]));
    else if (last_col) gx = 2 * (longint'(curr_line[c]) - longint'(prev_line[c - 1]));
    else gx = longint'(curr_line[c + 1]) - longint'(prev_line[c - 1]);
    if (flush) gy = 2 * (longint'(curr_line[c]) - longint'(prev_line[c]));
    else if (row_pos == 1) gy = 2 * (longint'(value) - longint'(curr_line[c]));
    else gy = longint'(value) - longint'(prev_line[c]);
    out_row = row_pos - 1'b1;
    res.grad_x = gx[GradW-1:0];
    res.grad_y = gy[GradW-1:0];
    res.row    = out_row[RowW-1:0];
    res.col    = c[ColW-1:0];
    res.last   = flush && last_col;
    expected_grads.push_back(res);
    prev_line[c] = curr_line[c];
    if (!flush) curr_line[c] = value;
    if (!last_col) begin
      col_pos = c + 1;
    end else if (flush) begin
      col_pos  = 0;
      row_pos  = '0;
      in_drain = 1'b0;
      frames_done++;
    end else begin
      col_pos = 0;
      row_pos = row_pos + 1'b1;
      if (row_pos >= h) in_drain = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, results_checked, got, want);
  endtask

  always @(posedge clk_i) begin
    gradient_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_grads.size() == 0) begin
        report_mismatch("unexpected result row", longint'(pixel_row_o), -1);
      end else begin
        want = expected_grads.pop_front();
        if (grad_x_half_o !== want.grad_x)
          report_mismatch("grad_x_half", longint'(grad_x_half_o),
                          longint'($signed(want.grad_x)));
        if (grad_y_half_o !== want.grad_y)
          report_mismatch("grad_y_half", longint'(grad_y_half_o),
                          longint'($signed(want.grad_y)));
        if (pixel_row_o !== want.row)
          report_mismatch("pixel_row", longint'(pixel_row_o), longint'(want.row));
        if (pixel_col_o !== want.col)
          report_mismatch("pixel_col", longint'(pixel_col_o), longint'(want.col));
        if (frame_last_o !== want.last)
          report_mismatch("frame_last", longint'(frame_last_o), longint'(want.last));
      end
      results_checked++;
    end
  end

  // The output side stalls at random, or holds off for a counted stretch.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles_left != 0) begin
        out_stall_i <= 1'b1;
        hold_cycles_left--;
      end else begin
        out_stall_i <= stalls_on && ($urandom_range(0, 99) < 16);
      end
    end
  end

  task automatic send_item(input item_kind_e kind, input logic [SampleInW-1:0] value);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    sample_i   <= value;
    do @(posedge clk_i); while (in_stall_o);
    items_accepted++;
    predict_gradient(kind, value);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_grads.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_IMAGE_WIDTH) cfg_width = value;
    else if (index == CFG_IMAGE_HEIGHT) cfg_height = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // Sends items until the frame in progress has drained. With noise, a stray
  // flush is offered outside the drain and a pixel during it.
  task automatic run_frame(input int unsigned noise_pct);
    int unsigned          start;
    logic [SampleInW-1:0] value;
    item_kind_e           kind;
    start = frames_done;
    while (frames_done == start) begin
      value = SampleInW'($urandom());
      kind  = in_drain ? KIND_FLUSH : KIND_PIXEL;
      if ($urandom_range(0, 99) < noise_pct) kind = in_drain ? KIND_PIXEL : KIND_FLUSH;
      send_item(kind, value);
    end
  endtask

  task automatic test_reset_height();
    write_reg(CFG_IMAGE_WIDTH, 13'd2);
    run_frame(0);
  endtask

  task automatic test_extreme_samples();
    logic [SampleInW-1:0] corner_pixels [9];
    corner_pixels = '{16'h0000, 16'hFFFF, 16'h0000,
                      16'hFFFF, 16'h0000, 16'hFFFF,
                      16'h5555, 16'hFFFF, 16'hAAAA};
    set_frame(13'd3, 13'd3);
    send_item(KIND_FLUSH, 16'hFFFF);
    foreach (corner_pixels[i]) send_item(KIND_PIXEL, corner_pixels[i]);
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_FLUSH, 16'h0000);
    send_item(KIND_PIXEL, 16'h1234);
    send_item(KIND_FLUSH, 16'h0000);
  endtask

  task automatic test_register_clamps();
    set_frame(13'd0, 13'd1);
    write_reg(CfgUnmapped, 13'h1FFF);
    run_frame(10);
    set_frame(13'd1, 13'd0);
    run_frame(10);
  endtask

  task automatic test_mid_frame_change();
    set_frame(13'd6, 13'd8);
    repeat (18) send_item(KIND_PIXEL, SampleInW'($urandom()));
    wait_idle();
    write_reg(CFG_IMAGE_HEIGHT, 13'd2);
    write_reg(CFG_IMAGE_WIDTH, 13'd4);
    run_frame(0);
  endtask

  task automatic test_wide_frames();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_frame(13'd4096, 13'd2);
    run_frame(0);
    wait_idle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    set_frame(13'h1FFF, 13'd0);
    run_frame(3);
  endtask

  task automatic test_tall_frames();
    set_frame(13'd2, 13'd4096);
    run_frame(2);
    set_frame(13'd1, 13'h1FFF);
    run_frame(0);
  endtask

  task automatic test_back_pressure();
    set_frame(13'd7, 13'd5);
    hold_cycles_left = HoldOffCycles;
    run_frame(0);
    wait_idle();
    run_frame(5);
  endtask

  task automatic test_random_frames();
    int unsigned first;
    int unsigned w;
    int unsigned h;
    first = items_accepted - items_ignored;
    while (items_accepted - items_ignored - first < RandomItems) begin
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 99) < 85) begin
          w = $urandom_range(2, 16);
          h = $urandom_range(2, 10);
        end else begin
          w = $urandom_range(17, 200);
          h = $urandom_range(2, 4);
        end
        set_frame(w[CfgDataW-1:0], h[CfgDataW-1:0]);
      end else if ($urandom_range(0, 99) < 10) begin
        wait_idle();
      end
      run_frame(5);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    kind_i           = 1'b0;
    sample_i         = '0;
    col_pos          = 0;
    row_pos          = '0;
    in_drain         = 1'b0;
    cfg_width        = WidthReset;
    cfg_height       = HeightReset;
    items_accepted   = 0;
    items_ignored    = 0;
    frames_done      = 0;
    results_checked  = 0;
    mismatches       = 0;
    hold_cycles_left = 0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_height();
    test_extreme_samples();
    test_register_clamps();
    test_mid_frame_change();
    test_back_pressure();
    test_wide_frames();
    test_tall_frames();
    test_random_frames();
    wait_idle();

    $display("covered %0d frames: %0d items accepted, %0d of them ignored flushes",
             frames_done, items_accepted, items_ignored);
    $display("checked %0d gradient results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
